// ----- rtl/rtnh_pkg.sv -----
// ----------------------------------------------------------------------------
// rtnh_pkg: shared types and constants for the ray/triangle nearest-hit block
// Operand and destination codes for the multiply-accumulate program, the
// sequencer states and default widths.
// ----------------------------------------------------------------------------
package rtnh_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int BODY_BITS_DEF  = 8;
  localparam int FACE_BITS_DEF  = 16;
  localparam int DIST_BITS      = 31;
  localparam int DIG_BITS       = 16;
  localparam int Q_FRAC_BITS    = 16;
  localparam int NUM_UOPS       = 24;
  localparam int UOP_BITS       = 5;
  localparam int CFG_IDX_BITS   = 3;
  localparam int DIR_Z_RESET    = 65536;

  localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_Z    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_DIRECTION_X = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_DIRECTION_Y = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_DIRECTION_Z = 3'd5;

  typedef enum logic [4:0] {
    OP_DX, OP_DY, OP_DZ, OP_TX, OP_TY, OP_TZ,
    OP_E1X, OP_E1Y, OP_E1Z, OP_E2X, OP_E2Y, OP_E2Z,
    OP_P0, OP_P1, OP_P2, OP_Q0, OP_Q1, OP_Q2
  } opnd_t;

  typedef enum logic [3:0] {
    DST_NONE, DST_P0, DST_P1, DST_P2, DST_Q0, DST_Q1, DST_Q2,
    DST_DET, DST_U, DST_V, DST_T
  } dst_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ISSUE, ST_WAIT, ST_STORE, ST_NORM, ST_CHKA, ST_CHKB,
    ST_SAT, ST_DIV, ST_UPD, ST_FINISH
  } state_t;

  typedef struct packed {
    opnd_t a;
    opnd_t b;
    logic  neg;
    logic  clr;
    dst_t  dst;
  } uop_t;

  typedef struct packed {
    logic start;
    logic clr;
  } mac_ctl_t;

  // Program: pvec = dir x e2, qvec = tvec x e1, then the four dot products.
  function automatic uop_t uop(input logic [UOP_BITS-1:0] k);
    uop_t u;
    u = '{a: OP_DX, b: OP_E1X, neg: 1'b0, clr: 1'b1, dst: DST_NONE};
    case (k)
      5'd0:  u = '{OP_DY,  OP_E2Z, 1'b0, 1'b1, DST_NONE};
      5'd1:  u = '{OP_DZ,  OP_E2Y, 1'b1, 1'b0, DST_P0};
      5'd2:  u = '{OP_DZ,  OP_E2X, 1'b0, 1'b1, DST_NONE};
      5'd3:  u = '{OP_DX,  OP_E2Z, 1'b1, 1'b0, DST_P1};
      5'd4:  u = '{OP_DX,  OP_E2Y, 1'b0, 1'b1, DST_NONE};
      5'd5:  u = '{OP_DY,  OP_E2X, 1'b1, 1'b0, DST_P2};
      5'd6:  u = '{OP_TY,  OP_E1Z, 1'b0, 1'b1, DST_NONE};
      5'd7:  u = '{OP_TZ,  OP_E1Y, 1'b1, 1'b0, DST_Q0};
      5'd8:  u = '{OP_TZ,  OP_E1X, 1'b0, 1'b1, DST_NONE};
      5'd9:  u = '{OP_TX,  OP_E1Z, 1'b1, 1'b0, DST_Q1};
      5'd10: u = '{OP_TX,  OP_E1Y, 1'b0, 1'b1, DST_NONE};
      5'd11: u = '{OP_TY,  OP_E1X, 1'b1, 1'b0, DST_Q2};
      5'd12: u = '{OP_E1X, OP_P0,  1'b0, 1'b1, DST_NONE};
      5'd13: u = '{OP_E1Y, OP_P1,  1'b0, 1'b0, DST_NONE};
      5'd14: u = '{OP_E1Z, OP_P2,  1'b0, 1'b0, DST_DET};
      5'd15: u = '{OP_TX,  OP_P0,  1'b0, 1'b1, DST_NONE};
      5'd16: u = '{OP_TY,  OP_P1,  1'b0, 1'b0, DST_NONE};
      5'd17: u = '{OP_TZ,  OP_P2,  1'b0, 1'b0, DST_U};
      5'd18: u = '{OP_DX,  OP_Q0,  1'b0, 1'b1, DST_NONE};
      5'd19: u = '{OP_DY,  OP_Q1,  1'b0, 1'b0, DST_NONE};
      5'd20: u = '{OP_DZ,  OP_Q2,  1'b0, 1'b0, DST_V};
      5'd21: u = '{OP_E2X, OP_Q0,  1'b0, 1'b1, DST_NONE};
      5'd22: u = '{OP_E2Y, OP_Q1,  1'b0, 1'b0, DST_NONE};
      5'd23: u = '{OP_E2Z, OP_Q2,  1'b0, 1'b0, DST_T};
      default: u = '{OP_DX, OP_E1X, 1'b0, 1'b1, DST_NONE};
    endcase
    return u;
  endfunction

endpackage

// ----- rtl/rtnh_tri_if.sv -----
// ----------------------------------------------------------------------------
// rtnh_tri_if: triangle input channel
// Valid/ready channel carrying three vertices, body and face index and the
// last-triangle marker.
// ----------------------------------------------------------------------------
interface rtnh_tri_if #(
  parameter int CW = 32,
  parameter int BW = 8,
  parameter int FW = 16
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] vertex_a_x;
  logic signed [CW-1:0] vertex_a_y;
  logic signed [CW-1:0] vertex_a_z;
  logic signed [CW-1:0] vertex_b_x;
  logic signed [CW-1:0] vertex_b_y;
  logic signed [CW-1:0] vertex_b_z;
  logic signed [CW-1:0] vertex_c_x;
  logic signed [CW-1:0] vertex_c_y;
  logic signed [CW-1:0] vertex_c_z;
  logic [BW-1:0]        body_index;
  logic [FW-1:0]        face_index;
  logic                 last_triangle;

  modport source (
    output valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
           vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, body_index,
           face_index, last_triangle,
    input  ready
  );
  modport sink (
    input  valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
           vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z, body_index,
           face_index, last_triangle,
    output ready
  );
endinterface

// ----- rtl/rtnh_hit_if.sv -----
// ----------------------------------------------------------------------------
// rtnh_hit_if: nearest-hit result channel
// Valid/ready channel carrying the hit flag, indices and distance.
// ----------------------------------------------------------------------------
interface rtnh_hit_if import rtnh_pkg::*; #(
  parameter int BW = 8,
  parameter int FW = 16
);
  logic                 valid;
  logic                 ready;
  logic                 hit_found;
  logic [BW-1:0]        hit_body;
  logic [FW-1:0]        hit_face;
  logic [DIST_BITS-1:0] hit_distance;

  modport source (
    output valid, hit_found, hit_body, hit_face, hit_distance,
    input  ready
  );
  modport sink (
    input  valid, hit_found, hit_body, hit_face, hit_distance,
    output ready
  );
endinterface

// ----- rtl/rtnh_mac.sv -----
// ----------------------------------------------------------------------------
// rtnh_mac: shared digit-serial multiply-accumulate unit
// Multiplies a short signed operand by a wide signed operand one 16-bit
// digit per cycle, most significant digit first, then adds the product into
// the accumulator (or loads it when clr is set).
// ----------------------------------------------------------------------------
module rtnh_mac import rtnh_pkg::*; #(
  parameter  int CW  = COORD_BITS_DEF,
  localparam int AOW = CW + 2,
  localparam int BW  = 2 * CW + 3,
  localparam int AW  = 3 * CW + 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mac_ctl_t              ctl,
  input  logic signed [AOW-1:0] a_op,
  input  logic signed [BW-1:0]  b_op,
  output logic signed [AW-1:0]  acc,
  output logic                  done
);

  localparam int ND  = (BW + DIG_BITS - 1) / DIG_BITS;
  localparam int EW  = ND * DIG_BITS;
  localparam int PW  = AOW + DIG_BITS + 1;
  localparam int PHW = $clog2(ND + 2);
  localparam int IXW = $clog2(ND);

  logic [PHW-1:0]         ph_r;
  logic                   busy_r;
  logic signed [PW-1:0]   prod_r;
  logic signed [AW-1:0]   pr_r;
  logic signed [AW-1:0]   acc_r;
  logic signed [EW-1:0]   b_ext;
  logic [IXW-1:0]         dig_idx;
  logic [DIG_BITS-1:0]    dig_raw;
  logic signed [DIG_BITS:0] dig_s;
  logic                   in_mul, in_fold, in_add;

  assign b_ext   = EW'(b_op);
  assign dig_idx = IXW'(ND - 1) - ph_r[IXW-1:0];
  assign dig_raw = b_ext[dig_idx*DIG_BITS +: DIG_BITS];
  // Only the top digit carries the sign; the rest are unsigned.
  assign dig_s   = {(dig_idx == IXW'(ND - 1)) ? b_ext[EW-1] : 1'b0, dig_raw};

  assign in_mul  = busy_r && (ph_r < PHW'(ND));
  assign in_fold = busy_r && (ph_r >= PHW'(1)) && (ph_r <= PHW'(ND));
  assign in_add  = busy_r && (ph_r == PHW'(ND + 1));
  assign done    = in_add;
  assign acc     = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r   <= '0;
    end else if (ctl.start) begin
      busy_r <= 1'b1;
      ph_r   <= '0;
    end else if (busy_r) begin
      ph_r <= ph_r + PHW'(1);
      if (in_add) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_mul) begin
      prod_r <= a_op * dig_s;
    end
    if (in_fold) begin
      if (ph_r == PHW'(1)) begin
        pr_r <= AW'(prod_r);
      end else begin
        pr_r <= (pr_r <<< DIG_BITS) + AW'(prod_r);
      end
    end
    if (in_add) begin
      acc_r <= (ctl.clr ? '0 : acc_r) + pr_r;
    end
  end

endmodule

// ----- rtl/ray_triangle_nearest_hit.sv -----
// ----------------------------------------------------------------------------
// ray_triangle_nearest_hit: nearest triangle hit along one configured ray
// Exact fixed-point Moller-Trumbore test with a shared multiplier and a
// restoring divider, keeping the nearest hit over a stream of triangles.
// ----------------------------------------------------------------------------
// The ray origin and direction sit in six configuration registers. The user
// must write them only while the block is idle; the block itself does not
// enforce this. Each triangle runs a program of 24 products on one shared
// digit-serial multiply-accumulate unit, which takes the wide operand in
// ND = ceil((2*COORD_BITS+3)/16) digits (5 at 32-bit coordinates). A triangle
// that passes the inside tests then goes through the one-bit-per-cycle
// divider that forms t. The input is not ready while a triangle is in
// progress. The result for a scene is offered after its last triangle and
// waits in an output register while the next scene starts.
// ----------------------------------------------------------------------------
module ray_triangle_nearest_hit import rtnh_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int BODY_BITS  = BODY_BITS_DEF,
  parameter int FACE_BITS  = FACE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]   cfg_data,
  rtnh_tri_if.sink                in_tri,
  rtnh_hit_if.source              out_hit
);

  localparam int CW  = COORD_BITS;
  localparam int EW  = CW + 1;
  localparam int AOW = CW + 2;
  localparam int BW  = 2 * CW + 3;
  localparam int AW  = 3 * CW + 6;
  localparam int SW  = AW + DIST_BITS - Q_FRAC_BITS;
  localparam int RW  = AW + DIST_BITS;

  // Configuration
  logic signed [CW-1:0] org_x_r, org_y_r, org_z_r;
  logic signed [CW-1:0] dir_x_r, dir_y_r, dir_z_r;

  // Per-triangle operands
  logic signed [EW-1:0] e1x_r, e1y_r, e1z_r, e2x_r, e2y_r, e2z_r;
  logic signed [EW-1:0] tvx_r, tvy_r, tvz_r;
  logic [BODY_BITS-1:0] body_r;
  logic [FACE_BITS-1:0] face_r;
  logic                 last_r;
  logic signed [BW-1:0] p0_r, p1_r, p2_r, q0_r, q1_r, q2_r;
  logic signed [AW-1:0] det_r, u_r, v_r, t_r;
  logic                 ok_r;

  // Divider
  logic signed [RW-1:0]   rem_r, dv_r;
  logic [DIST_BITS-1:0]   quo_r;
  logic [4:0]             cnt_r;

  // Running best
  logic [DIST_BITS-1:0] best_dist_r;
  logic [BODY_BITS-1:0] best_body_r;
  logic [FACE_BITS-1:0] best_face_r;
  logic                 any_hit_r;

  // Result register
  logic                 out_valid_r;
  logic                 out_found_r;
  logic [BODY_BITS-1:0] out_body_r;
  logic [FACE_BITS-1:0] out_face_r;
  logic [DIST_BITS-1:0] out_dist_r;

  state_t               state_r, state_nxt;
  logic [UOP_BITS-1:0]  op_r;
  uop_t                 cur;
  mac_ctl_t             mac_ctl;
  logic                 mac_done;
  logic signed [AW-1:0] mac_acc;
  logic signed [EW-1:0] a_raw;
  logic signed [AOW-1:0] a_op;
  logic signed [BW-1:0] b_op;

  logic in_fire, out_fire;
  logic det_zero, chk_a, uv_le, t_sat, div_ge, div_last, better, emit_ok;
  logic do_accept, do_store, do_norm, do_chka, do_div_init, do_div_step;
  logic do_update, do_emit;

  assign in_fire  = in_tri.valid && in_tri.ready;
  assign out_fire = out_valid_r && out_hit.ready;

  assign cur = uop(op_r);

  always_comb begin
    case (cur.a)
      OP_DX:   a_raw = EW'(dir_x_r);
      OP_DY:   a_raw = EW'(dir_y_r);
      OP_DZ:   a_raw = EW'(dir_z_r);
      OP_TX:   a_raw = tvx_r;
      OP_TY:   a_raw = tvy_r;
      OP_TZ:   a_raw = tvz_r;
      OP_E1X:  a_raw = e1x_r;
      OP_E1Y:  a_raw = e1y_r;
      OP_E1Z:  a_raw = e1z_r;
      OP_E2X:  a_raw = e2x_r;
      OP_E2Y:  a_raw = e2y_r;
      OP_E2Z:  a_raw = e2z_r;
      default: a_raw = '0;
    endcase
  end

  // A subtracting step negates the short operand, which needs one bit more.
  assign a_op = cur.neg ? -AOW'(a_raw) : AOW'(a_raw);

  always_comb begin
    case (cur.b)
      OP_E1X:  b_op = BW'(e1x_r);
      OP_E1Y:  b_op = BW'(e1y_r);
      OP_E1Z:  b_op = BW'(e1z_r);
      OP_E2X:  b_op = BW'(e2x_r);
      OP_E2Y:  b_op = BW'(e2y_r);
      OP_E2Z:  b_op = BW'(e2z_r);
      OP_P0:   b_op = p0_r;
      OP_P1:   b_op = p1_r;
      OP_P2:   b_op = p2_r;
      OP_Q0:   b_op = q0_r;
      OP_Q1:   b_op = q1_r;
      OP_Q2:   b_op = q2_r;
      default: b_op = '0;
    endcase
  end

  rtnh_mac #(.CW(CW)) u_rtnh_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .a_op  (a_op),
    .b_op  (b_op),
    .acc   (mac_acc),
    .done  (mac_done)
  );

  // Decisions on the normalised det, U, V and T (det made positive).
  assign det_zero = (det_r == '0);
  assign chk_a    = !u_r[AW-1] && !v_r[AW-1] && !t_r[AW-1] && (t_r != '0) &&
                    (u_r <= det_r);
  assign uv_le    = ((AW+1)'(u_r) + (AW+1)'(v_r)) <= (AW+1)'(det_r);
  // A quotient of 2^31 or more saturates and can never beat the best.
  assign t_sat    = SW'(t_r) >= (SW'(det_r) <<< (DIST_BITS - Q_FRAC_BITS));
  assign div_ge   = rem_r >= dv_r;
  assign div_last = (cnt_r == 5'(DIST_BITS - 1));
  assign better   = (quo_r != '0) && (quo_r < best_dist_r);
  assign emit_ok  = !out_valid_r || out_hit.ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_fire) state_nxt = ST_ISSUE;
      ST_ISSUE:  state_nxt = ST_WAIT;
      ST_WAIT:   if (mac_done) state_nxt = ST_STORE;
      ST_STORE: begin
        if (op_r == UOP_BITS'(NUM_UOPS - 1)) state_nxt = ST_NORM;
        else                                 state_nxt = ST_ISSUE;
      end
      ST_NORM:   state_nxt = det_zero ? ST_FINISH : ST_CHKA;
      ST_CHKA:   state_nxt = ST_CHKB;
      ST_CHKB:   state_nxt = (ok_r && uv_le) ? ST_SAT : ST_FINISH;
      ST_SAT:    state_nxt = t_sat ? ST_FINISH : ST_DIV;
      ST_DIV:    if (div_last) state_nxt = ST_UPD;
      ST_UPD:    state_nxt = ST_FINISH;
      ST_FINISH: if (!last_r || emit_ok) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Control strobes
  always_comb begin
    in_tri.ready = (state_r == ST_IDLE);
    mac_ctl      = '{start: (state_r == ST_ISSUE), clr: cur.clr};
    do_accept    = (state_r == ST_IDLE) && in_fire;
    do_store     = (state_r == ST_STORE);
    do_norm      = (state_r == ST_NORM);
    do_chka      = (state_r == ST_CHKA);
    do_div_init  = (state_r == ST_SAT);
    do_div_step  = (state_r == ST_DIV);
    do_update    = (state_r == ST_UPD) && better;
    do_emit      = (state_r == ST_FINISH) && last_r && emit_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (do_accept) begin
        op_r <= '0;
      end else if (do_store) begin
        op_r <= op_r + UOP_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r <= '0;
      org_y_r <= '0;
      org_z_r <= '0;
      dir_x_r <= '0;
      dir_y_r <= '0;
      dir_z_r <= CW'(DIR_Z_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X:    org_x_r <= cfg_data;
        REG_ORIGIN_Y:    org_y_r <= cfg_data;
        REG_ORIGIN_Z:    org_z_r <= cfg_data;
        REG_DIRECTION_X: dir_x_r <= cfg_data;
        REG_DIRECTION_Y: dir_y_r <= cfg_data;
        REG_DIRECTION_Z: dir_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (do_accept) begin
      e1x_r  <= EW'(in_tri.vertex_b_x) - EW'(in_tri.vertex_a_x);
      e1y_r  <= EW'(in_tri.vertex_b_y) - EW'(in_tri.vertex_a_y);
      e1z_r  <= EW'(in_tri.vertex_b_z) - EW'(in_tri.vertex_a_z);
      e2x_r  <= EW'(in_tri.vertex_c_x) - EW'(in_tri.vertex_a_x);
      e2y_r  <= EW'(in_tri.vertex_c_y) - EW'(in_tri.vertex_a_y);
      e2z_r  <= EW'(in_tri.vertex_c_z) - EW'(in_tri.vertex_a_z);
      tvx_r  <= EW'(org_x_r) - EW'(in_tri.vertex_a_x);
      tvy_r  <= EW'(org_y_r) - EW'(in_tri.vertex_a_y);
      tvz_r  <= EW'(org_z_r) - EW'(in_tri.vertex_a_z);
      body_r <= in_tri.body_index;
      face_r <= in_tri.face_index;
      last_r <= in_tri.last_triangle;
    end
    if (do_store) begin
      case (cur.dst)
        DST_P0:  p0_r  <= BW'(mac_acc);
        DST_P1:  p1_r  <= BW'(mac_acc);
        DST_P2:  p2_r  <= BW'(mac_acc);
        DST_Q0:  q0_r  <= BW'(mac_acc);
        DST_Q1:  q1_r  <= BW'(mac_acc);
        DST_Q2:  q2_r  <= BW'(mac_acc);
        DST_DET: det_r <= mac_acc;
        DST_U:   u_r   <= mac_acc;
        DST_V:   v_r   <= mac_acc;
        DST_T:   t_r   <= mac_acc;
        default: ;
      endcase
    end
    if (do_norm && det_r[AW-1]) begin
      det_r <= -det_r;
      u_r   <= -u_r;
      v_r   <= -v_r;
      t_r   <= -t_r;
    end
    if (do_chka) begin
      ok_r <= chk_a;
    end
    if (do_div_init) begin
      rem_r <= RW'(t_r) <<< Q_FRAC_BITS;
      dv_r  <= RW'(det_r) <<< (DIST_BITS - 1);
      quo_r <= '0;
      cnt_r <= '0;
    end else if (do_div_step) begin
      if (div_ge) begin
        rem_r <= rem_r - dv_r;
      end
      dv_r  <= dv_r >>> 1;
      quo_r <= {quo_r[DIST_BITS-2:0], div_ge};
      cnt_r <= cnt_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_dist_r <= '1;
      best_body_r <= '0;
      best_face_r <= '0;
      any_hit_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (do_update) begin
        best_dist_r <= quo_r;
        best_body_r <= body_r;
        best_face_r <= face_r;
        any_hit_r   <= 1'b1;
      end else if (do_emit) begin
        best_dist_r <= '1;
        best_body_r <= '0;
        best_face_r <= '0;
        any_hit_r   <= 1'b0;
      end
      if (do_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      out_found_r <= any_hit_r;
      out_body_r  <= best_body_r;
      out_face_r  <= best_face_r;
      out_dist_r  <= best_dist_r;
    end
  end

  assign out_hit.valid        = out_valid_r;
  assign out_hit.hit_found    = out_found_r;
  assign out_hit.hit_body     = out_body_r;
  assign out_hit.hit_face     = out_face_r;
  assign out_hit.hit_distance = out_dist_r;

endmodule

// ----- rtl/rtnh_check.sv -----
// ----------------------------------------------------------------------------
// rtnh_check: port-level checks for the nearest-hit block
// Watches the handshakes and the consistency of reported results.
// ----------------------------------------------------------------------------
module rtnh_check import rtnh_pkg::*; #(
  parameter int BODY_W = BODY_BITS_DEF,
  parameter int FACE_W = FACE_BITS_DEF
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 hit_found,
  input logic [BODY_W-1:0]    hit_body,
  input logic [FACE_W-1:0]    hit_face,
  input logic [DIST_BITS-1:0] hit_distance
);

  // A stalled result beat must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(hit_distance))
    else $error("result beat changed while stalled");

  // One triangle at a time: the input closes after each accepted beat.
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted a second triangle while busy");

  a_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !hit_found |-> hit_distance == '1 && hit_body == '0 &&
                                hit_face == '0)
    else $error("empty result carries hit data");

  a_hit_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && hit_found |-> hit_distance != '0 && hit_distance != '1)
    else $error("hit reported with impossible distance");

endmodule

bind ray_triangle_nearest_hit rtnh_check #(
  .BODY_W (BODY_BITS),
  .FACE_W (FACE_BITS)
) u_rtnh_check (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_tri.valid),
  .in_ready     (in_tri.ready),
  .out_valid    (out_hit.valid),
  .out_ready    (out_hit.ready),
  .hit_found    (out_hit.hit_found),
  .hit_body     (out_hit.hit_body),
  .hit_face     (out_hit.hit_face),
  .hit_distance (out_hit.hit_distance)
);
